// ----- rtl/jsu_pkg.sv -----
// Shared types for the JSON string unescaper.
// No dependencies; imported by the decoder, the output buffer and the top level.
package jsu_pkg;

    // Up to four output bytes come from one raw input byte.
    localparam int unsigned MAX_RES = 4;

    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;  // bytes[0] goes out first
        logic [2:0]              cnt;    // number of valid bytes, 0..MAX_RES
        logic                    last;   // raw byte closed the string
    } t_res;

endpackage

// ----- rtl/jsu_if.sv -----
// Valid/ready channel interfaces of the JSON string unescaper.
// No dependencies.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;

    modport source (output valid, output out_byte, output run_last, output string_last,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_last,
                    output ready);
endinterface

// ----- rtl/jsu_decode.sv -----
// Escape decoder: escape state registers and the per-byte decode logic.
// Depends on jsu_pkg (t_res).
module jsu_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output jsu_pkg::t_res o_res
);
    import jsu_pkg::*;

    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_U      = 8'h75;
    localparam logic [7:0] C_B      = 8'h62;
    localparam logic [7:0] C_F      = 8'h66;
    localparam logic [7:0] C_N      = 8'h6E;
    localparam logic [7:0] C_R      = 8'h72;
    localparam logic [7:0] C_T      = 8'h74;

    localparam logic [15:0] UTF8_1_MAX = 16'h007F;
    localparam logic [15:0] UTF8_2_MAX = 16'h07FF;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_HEX  = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [1:0] r_cnt, n_cnt;
    logic [7:0] r_held [3];
    logic       wr_held;

    logic [3:0]  d0, d1, d2, d3;
    logic        h1, h2, h3;
    logic [15:0] code;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        if (c <= 8'h39) begin
            t = c - 8'h30;
        end else if (c >= 8'h61) begin
            t = c - 8'h57;
        end else begin
            t = c - 8'h37;
        end
        hex_val = t[3:0];
    endfunction

    function automatic logic [7:0] map_esc(input logic [7:0] c);
        unique case (c)
            C_B:     map_esc = 8'h08;
            C_F:     map_esc = 8'h0C;
            C_N:     map_esc = 8'h0A;
            C_R:     map_esc = 8'h0D;
            C_T:     map_esc = 8'h09;
            default: map_esc = c;
        endcase
    endfunction

    // \uXXXX value: leading hex digits only, first is known to be hex
    always_comb begin
        d0 = hex_val(r_held[0]);
        d1 = hex_val(r_held[1]);
        d2 = hex_val(r_held[2]);
        d3 = hex_val(i_byte);
        h1 = is_hex(r_held[1]);
        h2 = h1 && is_hex(r_held[2]);
        h3 = h2 && is_hex(i_byte);
        priority if (!h1) begin
            code = {12'd0, d0};
        end else if (!h2) begin
            code = {8'd0, d0, d1};
        end else if (!h3) begin
            code = {4'd0, d0, d1, d2};
        end else begin
            code = {d0, d1, d2, d3};
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        wr_held  = 1'b0;
        o_res    = '0;
        o_res.last = i_last;
        unique case (r_phase)
            PH_ESC: begin
                if (i_byte == C_U && !i_last) begin
                    n_phase = PH_HEX;
                    n_cnt   = 2'd0;
                end else begin
                    o_res.bytes[0] = map_esc(i_byte);
                    o_res.cnt      = 3'd1;
                    n_phase        = PH_TEXT;
                end
            end
            PH_HEX: begin
                priority if (r_cnt == 2'd0 && !is_hex(i_byte)) begin
                    // not a \u escape after all: 'u' then the byte as plain text
                    o_res.bytes[0] = C_U;
                    n_cnt          = 2'd0;
                    if (i_byte == C_BSLASH && !i_last) begin
                        o_res.cnt = 3'd1;
                        n_phase   = PH_ESC;
                    end else begin
                        o_res.bytes[1] = i_byte;
                        o_res.cnt      = 3'd2;
                        n_phase        = PH_TEXT;
                    end
                end else if (r_cnt == 2'd3) begin
                    n_phase = PH_TEXT;
                    n_cnt   = 2'd0;
                    if (code <= UTF8_1_MAX) begin
                        o_res.bytes[0] = code[7:0];
                        o_res.cnt      = 3'd1;
                    end else if (code <= UTF8_2_MAX) begin
                        o_res.bytes[0] = {3'b110, code[10:6]};
                        o_res.bytes[1] = {2'b10, code[5:0]};
                        o_res.cnt      = 3'd2;
                    end else begin
                        o_res.bytes[0] = {4'b1110, code[15:12]};
                        o_res.bytes[1] = {2'b10, code[11:6]};
                        o_res.bytes[2] = {2'b10, code[5:0]};
                        o_res.cnt      = 3'd3;
                    end
                end else if (i_last) begin
                    // string ended inside \u: replay held bytes as plain text
                    n_phase        = PH_TEXT;
                    n_cnt          = 2'd0;
                    o_res.bytes[0] = C_U;
                    if (r_cnt == 2'd0) begin
                        o_res.bytes[1] = i_byte;
                        o_res.cnt      = 3'd2;
                    end else if (r_cnt == 2'd1) begin
                        o_res.bytes[1] = r_held[0];
                        o_res.bytes[2] = i_byte;
                        o_res.cnt      = 3'd3;
                    end else if (r_held[1] == C_BSLASH) begin
                        o_res.bytes[1] = r_held[0];
                        o_res.bytes[2] = map_esc(i_byte);
                        o_res.cnt      = 3'd3;
                    end else begin
                        o_res.bytes[1] = r_held[0];
                        o_res.bytes[2] = r_held[1];
                        o_res.bytes[3] = i_byte;
                        o_res.cnt      = 3'd4;
                    end
                end else begin
                    wr_held = 1'b1;
                    n_cnt   = r_cnt + 2'd1;
                end
            end
            default: begin
                if (i_byte == C_BSLASH && !i_last) begin
                    n_phase = PH_ESC;
                end else begin
                    o_res.bytes[0] = i_byte;
                    o_res.cnt      = 3'd1;
                    n_phase        = PH_TEXT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TEXT;
            r_cnt   <= 2'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && wr_held) begin
            r_held[r_cnt] <= i_byte;
        end
    end

endmodule

// ----- rtl/jsu_outbuf.sv -----
// Result register: holds one input's decoded bytes and sends one per cycle when ready.
// Depends on jsu_pkg (t_res) and jsu_out_if.
module jsu_outbuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  jsu_pkg::t_res i_res,
    output logic          o_can_take,
    jsu_out_if.source     o_out
);
    import jsu_pkg::*;

    logic [MAX_RES-1:0][7:0] r_bytes;
    logic [2:0]              r_cnt;
    logic [1:0]              r_idx;
    logic                    r_last;
    logic                    r_valid;
    logic                    at_end;

    assign at_end = ({1'b0, r_idx} + 3'd1) == r_cnt;

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_bytes[r_idx];
    assign o_out.run_last    = at_end;
    assign o_out.string_last = at_end && r_last;

    // free now, or the final byte leaves in this cycle
    assign o_can_take = !r_valid || (o_out.ready && at_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (r_valid && o_out.ready) begin
                if (at_end) begin
                    r_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
            if (i_load && i_res.cnt != 3'd0) begin
                r_valid <= 1'b1;
                r_idx   <= 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res.cnt != 3'd0) begin
            r_bytes <= i_res.bytes;
            r_cnt   <= i_res.cnt;
            r_last  <= i_res.last;
        end
    end

endmodule

// ----- rtl/json_string_unescape.sv -----
// Top level of the JSON string unescaper: decoder plus result register.
// Depends on jsu_pkg, jsu_if, jsu_decode and jsu_outbuf.
//
//   channel  | dir | payload                           | transaction
//   i_in     | in  | in_byte[7:0], in_last             | one raw byte of the string body
//   o_out    | out | out_byte[7:0], run_last, string_last | one decoded byte
//
// An input byte is decoded in the cycle it is accepted; its 0 to 4 output bytes
// leave the result register one per cycle, starting the next cycle, while o_out
// is ready. A new byte is accepted in the cycle the last pending output byte
// is taken.
// i_rst_n is synchronous: it clears the escape state and empties the result register.
// A stall on o_out holds the result and back-pressures i_in.
module json_string_unescape (
    input  logic     i_clk,
    input  logic     i_rst_n,
    jsu_in_if.sink   i_in,
    jsu_out_if.source o_out
);
    import jsu_pkg::*;

    t_res res;
    logic can_take;
    logic accept;

    assign i_in.ready = can_take;
    assign accept     = i_in.valid && can_take;

    jsu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.in_byte),
        .i_last   (i_in.in_last),
        .o_res    (res)
    );

    jsu_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_res      (res),
        .o_can_take (can_take),
        .o_out      (o_out)
    );

endmodule

// ----- rtl/jsu_check.sv -----
// Port-level checks for json_string_unescape, attached by bind.
// Depends only on the top level's ports.
module jsu_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       string_last
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
        else $error("stalled output changed");

    a_str_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && string_last |-> run_last)
        else $error("string_last without run_last");

    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_last |=> out_valid)
        else $error("final byte produced no output");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output empty");

endmodule

bind json_string_unescape jsu_check u_jsu_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (i_in.valid),
    .in_ready    (i_in.ready),
    .in_last     (i_in.in_last),
    .out_valid   (o_out.valid),
    .out_ready   (o_out.ready),
    .out_byte    (o_out.out_byte),
    .run_last    (o_out.run_last),
    .string_last (o_out.string_last)
);

// ----- dv/json_string_unescape_tb.sv -----
`timescale 1ns / 100ps
// Testbench for json_string_unescape: random and directed JSON string bodies,
// checked byte by byte against an in-bench decoder. Needs jsu_pkg, jsu_if and the RTL.
module json_string_unescape_tb;
    import jsu_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned STALL_LEN      = 300;
    localparam int unsigned MAX_REPORTS    = 10;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam string      ESC_SET   = "\"\\/bfnrt";

    typedef enum logic [1:0] {
        ST_TEXT = 2'd0,
        ST_ESC  = 2'd1,
        ST_HEX  = 2'd2
    } t_esc_state;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_last;
    } t_dec_byte;

    typedef logic [7:0] t_byte_q [$];

    logic clk = 1'b0;
    logic rst_n;

    jsu_in_if  in_if ();
    jsu_out_if out_if ();

    json_string_unescape u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 clk = ~clk;

    // decoder state mirrored in the bench
    t_esc_state esc_state = ST_TEXT;
    logic [1:0] digit_cnt = 2'd0;
    logic [7:0] u_digits [3];

    t_dec_byte decoded_q [$];

    bit          idle_en    = 1'b1;
    bit          run_active = 1'b0;
    int unsigned stall_req  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned raw_cnt      = 0;
    int unsigned string_cnt   = 0;
    int unsigned checked_cnt  = 0;
    int unsigned multi_cnt    = 0;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] escape_char(input logic [7:0] c);
        case (c)
            "b": return 8'h08;
            "f": return 8'h0C;
            "n": return 8'h0A;
            "r": return 8'h0D;
            "t": return 8'h09;
            default: return c;
        endcase
    endfunction

    // Decode one raw byte and queue the bytes it releases. Bytes that must be
    // reprocessed as plain text go back on the front of the work list.
    function automatic void unescape_byte(input logic [7:0] raw, input logic last);
        logic [8:0]  work [$];
        logic [7:0]  outq [$];
        logic [8:0]  cur;
        logic [7:0]  c;
        logic        l;
        logic [7:0]  q [4];
        logic [15:0] v;
        bit          stop;
        int          d;
        int          k;
        t_dec_byte   e;
        work.insert(work.size(), {last, raw});
        while (work.size() != 0) begin
            cur = work.pop_front();
            c = cur[7:0];
            l = cur[8];
            case (esc_state)
                ST_ESC: begin
                    if (c == CH_U && !l) begin
                        esc_state = ST_HEX;
                        digit_cnt = 2'd0;
                    end else begin
                        outq.insert(outq.size(), escape_char(c));
                        esc_state = ST_TEXT;
                    end
                end
                ST_HEX: begin
                    if (digit_cnt == 2'd0 && hex_digit(c) < 0) begin
                        outq.insert(outq.size(), CH_U);
                        esc_state = ST_TEXT;
                        work.push_front(cur);
                    end else if (digit_cnt == 2'd3) begin
                        q[0] = u_digits[0];
                        q[1] = u_digits[1];
                        q[2] = u_digits[2];
                        q[3] = c;
                        v = '0;
                        stop = 1'b0;
                        for (k = 0; k < 4; k++) begin
                            d = hex_digit(q[k]);
                            if (d < 0) stop = 1'b1;
                            if (!stop) v = {v[11:0], d[3:0]};
                        end
                        esc_state = ST_TEXT;
                        digit_cnt = 2'd0;
                        if (v <= 16'h007F) begin
                            outq.insert(outq.size(), v[7:0]);
                        end else if (v <= 16'h07FF) begin
                            outq.insert(outq.size(), 8'hC0 | 8'(v >> 6));
                            outq.insert(outq.size(), 8'h80 | 8'(v & 16'h003F));
                        end else begin
                            outq.insert(outq.size(), 8'hE0 | 8'(v >> 12));
                            outq.insert(outq.size(), 8'h80 | 8'((v >> 6) & 16'h003F));
                            outq.insert(outq.size(), 8'h80 | 8'(v & 16'h003F));
                        end
                    end else if (l) begin
                        // string ended inside \u: emit 'u', replay what was held
                        outq.insert(outq.size(), CH_U);
                        esc_state = ST_TEXT;
                        work.push_front(cur);
                        for (k = int'(digit_cnt) - 1; k >= 0; k--)
                            work.push_front({1'b0, u_digits[k]});
                        digit_cnt = 2'd0;
                    end else begin
                        u_digits[digit_cnt] = c;
                        digit_cnt = digit_cnt + 2'd1;
                    end
                end
                default: begin
                    if (c == CH_BSLASH && !l) begin
                        esc_state = ST_ESC;
                    end else begin
                        outq.insert(outq.size(), c);
                        esc_state = ST_TEXT;
                    end
                end
            endcase
        end
        while (outq.size() > MAX_RES) void'(outq.pop_back());
        if (outq.size() > 1) multi_cnt++;
        for (k = 0; k < outq.size(); k++) begin
            e.data        = outq[k];
            e.run_last    = (k == outq.size() - 1);
            e.string_last = (k == outq.size() - 1) && last;
            decoded_q.insert(decoded_q.size(), e);
        end
    endfunction

    function automatic void flag_mismatch(input string why);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) $display("%0t mismatch: %s", $time, why);
    endfunction

    // output check first, then prediction for the input transaction at this edge
    always @(posedge clk) begin : track_bytes
        t_dec_byte want;
        if (rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (decoded_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected byte %02h run_last %b string_last %b",
                        out_if.out_byte, out_if.run_last, out_if.string_last));
                end else begin
                    want = decoded_q.pop_front();
                    checked_cnt++;
                    if (want.data !== out_if.out_byte || want.run_last !== out_if.run_last ||
                        want.string_last !== out_if.string_last)
                        flag_mismatch($sformatf(
                            "expected %02h/%b/%b got %02h/%b/%b (byte/run_last/string_last)",
                            want.data, want.run_last, want.string_last,
                            out_if.out_byte, out_if.run_last, out_if.string_last));
                end
            end
            if (in_if.valid && in_if.ready) begin
                raw_cnt++;
                if (in_if.in_last) string_cnt++;
                unescape_byte(in_if.in_byte, in_if.in_last);
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if (!run_active || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles, %0d bytes outstanding",
                    WATCHDOG_LIMIT, decoded_q.size());
                $display("json_string_unescape_tb: FAIL");
                $finish;
            end
        end
    end

    // output side: random stalls, or one long hold-off on request
    initial begin : sink_side
        out_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (stall_req != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall_req) @(posedge clk);
                stall_req = 0;
            end else begin
                out_if.ready <= !(idle_en && $urandom_range(99) < 24);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (idle_en && $urandom_range(99) < 24) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        in_if.in_last <= last;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
    endtask

    task automatic send_string(input t_byte_q s);
        int i;
        for (i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'("0") + 8'(n);
        return ($urandom_range(1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (hex_digit(b) >= 0) b = 8'($urandom_range(255));
        return b;
    endfunction

    // Mostly well-formed string bodies; some escapes are broken on purpose and
    // some strings are cut short, so that they may end inside an escape.
    function automatic t_byte_q random_body();
        t_byte_q s;
        int unsigned nseg;
        int unsigned sel;
        int unsigned seg;
        int unsigned i;
        logic [15:0] v;
        nseg = $urandom_range(1, 6);
        for (seg = 0; seg < nseg; seg++) begin
            sel = $urandom_range(99);
            if (sel < 30) begin
                if ($urandom_range(9) == 0) s.insert(s.size(), 8'($urandom_range(255)));
                else s.insert(s.size(), 8'($urandom_range(8'h20, 8'h7E)));
            end else if (sel < 50) begin
                s.insert(s.size(), CH_BSLASH);
                s.insert(s.size(), ESC_SET[$urandom_range(ESC_SET.len() - 1)]);
            end else if (sel < 58) begin
                s.insert(s.size(), CH_BSLASH);
                s.insert(s.size(), 8'($urandom_range(255)));
            end else if (sel < 85) begin
                case ($urandom_range(3))
                    0: v = 16'($urandom_range(16'h007F));
                    1: v = 16'($urandom_range(16'h0080, 16'h07FF));
                    2: v = 16'($urandom_range(16'h0800, 16'hFFFF));
                    default: begin
                        case ($urandom_range(5))
                            0: v = 16'h0000;
                            1: v = 16'h007F;
                            2: v = 16'h0080;
                            3: v = 16'h07FF;
                            4: v = 16'h0800;
                            default: v = 16'hFFFF;
                        endcase
                    end
                endcase
                s.insert(s.size(), CH_BSLASH);
                s.insert(s.size(), CH_U);
                s.insert(s.size(), hex_char(v[15:12]));
                s.insert(s.size(), hex_char(v[11:8]));
                s.insert(s.size(), hex_char(v[7:4]));
                s.insert(s.size(), hex_char(v[3:0]));
            end else if (sel < 93) begin
                // leading hex digit, then arbitrary characters
                s.insert(s.size(), CH_BSLASH);
                s.insert(s.size(), CH_U);
                s.insert(s.size(), hex_char(4'($urandom_range(15))));
                for (i = 0; i < 3; i++) begin
                    if ($urandom_range(1)) s.insert(s.size(), hex_char(4'($urandom_range(15))));
                    else s.insert(s.size(), 8'($urandom_range(255)));
                end
            end else begin
                s.insert(s.size(), CH_BSLASH);
                s.insert(s.size(), CH_U);
                s.insert(s.size(), non_hex_byte());
            end
        end
        if ($urandom_range(99) < 15) begin
            i = $urandom_range(1, s.size());
            while (s.size() > i) void'(s.pop_back());
        end
        return s;
    endfunction

    task automatic test_directed();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("\\");          // trailing backslash
        send_text("\\u");         // lone \u at the end
        send_text("\\uZ");        // first char after \u not hex
        send_text("\\u1\\u");     // ends early with an escape among the held chars
        send_text("\\u00e9");     // two-byte form
        send_text("\\uFfFf");     // three-byte form, top value
    endtask

    task automatic test_random_strings(input int unsigned n);
        int unsigned stop_at;
        stop_at = raw_cnt + n;
        while (raw_cnt < stop_at) send_string(random_body());
    endtask

    task automatic test_back_pressure();
        int unsigned stop_at;
        stall_req = STALL_LEN;
        stop_at = raw_cnt + 40;
        while (raw_cnt < stop_at) send_string(random_body());
    endtask

    task automatic test_steady_stream();
        idle_en = 1'b0;
        test_random_strings(100);
        idle_en = 1'b1;
    endtask

    task automatic test_noise(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
        send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    initial begin : run_tests
        in_if.valid   = 1'b0;
        in_if.in_byte = 8'h00;
        in_if.in_last = 1'b0;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        run_active = 1'b1;

        test_directed();
        test_random_strings(210);
        test_back_pressure();
        test_steady_stream();
        test_noise(60);

        in_if.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        run_active = 1'b0;
        repeat (20) @(posedge clk);

        $display("summary: %0d raw bytes in %0d strings, %0d decoded bytes checked",
            raw_cnt, string_cnt, checked_cnt);
        $display("summary: %0d inputs gave several bytes, %0d mismatches",
            multi_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && decoded_q.size() == 0) begin
            $display("json_string_unescape_tb: PASS");
        end else begin
            $display("json_string_unescape_tb: FAIL");
        end
        $finish;
    end

endmodule
